// ===== design/lmsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsa_pkg
// shared types, constants and fixed-point helpers of the affine lms estimator
// ----------------------------------------------------------------------------
package lmsa_pkg;

    localparam int MODEL_SIZE_DEF = 4;
    localparam int QW             = 32;
    localparam int SQW            = 17;
    localparam int IDXW           = 5;
    localparam int CMDW           = 3;

    localparam logic [CMDW-1:0] CMD_STEP  = 3'd0;
    localparam logic [CMDW-1:0] CMD_GAIN  = 3'd1;
    localparam logic [CMDW-1:0] CMD_LOWER = 3'd2;
    localparam logic [CMDW-1:0] CMD_UPPER = 3'd3;
    localparam logic [CMDW-1:0] CMD_PARAM = 3'd4;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // datapath operation codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_EINIT = 3'd1;
    localparam logic [2:0] OP_EACC  = 3'd2;
    localparam logic [2:0] OP_EFIN  = 3'd3;
    localparam logic [2:0] OP_MUL   = 3'd4;
    localparam logic [2:0] OP_FINAL = 3'd5;

    // multiplier operand selects
    localparam logic [2:0] SRC_GAIN   = 3'd0;
    localparam logic [2:0] SRC_MATRIX = 3'd1;
    localparam logic [2:0] SRC_TMP    = 3'd2;

    localparam logic [2:0] SRC_DRIVE  = 3'd0;
    localparam logic [2:0] SRC_SQRT   = 3'd1;
    localparam logic [2:0] SRC_ERR    = 3'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] sel_a;
        logic [2:0] sel_b;
        logic [IDXW-1:0] entry;
        logic [3:0] row;
        logic [3:0] col;
        logic       load;
        logic       emit;
    } lmsa_cmd_t;

    typedef struct packed {
        logic prod_valid;
    } lmsa_stat_t;

    function automatic logic signed [QW-1:0] sat64(input logic signed [63:0] v);
        logic signed [QW-1:0] r;
        begin
            if (v > 64'sh0000_0000_7fff_ffff)
                r = Q_MAX;
            else if (v < -64'sh0000_0000_8000_0000)
                r = Q_MIN;
            else
                r = v[QW-1:0];
            return r;
        end
    endfunction

    function automatic logic signed [QW-1:0] qadd(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [QW:0] s;
        begin
            s = {a[QW-1], a} + {b[QW-1], b};
            if (s[QW] != s[QW-1])
                return s[QW] ? Q_MIN : Q_MAX;
            return s[QW-1:0];
        end
    endfunction

    function automatic logic signed [QW-1:0] qsub(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [QW:0] s;
        begin
            s = {a[QW-1], a} - {b[QW-1], b};
            if (s[QW] != s[QW-1])
                return s[QW] ? Q_MIN : Q_MAX;
            return s[QW-1:0];
        end
    endfunction

endpackage

// ===== design/lmsa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsa_datapath
// parameter stores, shared multiplier, error and update registers
// ----------------------------------------------------------------------------
module lmsa_datapath #(
    parameter int MODEL_SIZE = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lmsa_pkg::lmsa_cmd_t        cmd,
    output lmsa_pkg::lmsa_stat_t       stat,
    input  logic                      wr_en,
    input  logic [2:0]                wr_cmd,
    input  logic [4:0]                wr_index,
    input  logic signed [31:0]        wr_value,
    input  logic                      ld_en,
    input  logic signed [31:0]        ld_meas [4],
    input  logic signed [31:0]        ld_drive [4],
    input  logic [16:0]               sqrt_dt,
    output logic [4:0]                res_index,
    output logic signed [31:0]        res_value
);
    import lmsa_pkg::*;

    localparam int MAT   = MODEL_SIZE * MODEL_SIZE;
    localparam int NENT  = MODEL_SIZE + MAT;
    localparam int RW    = (MODEL_SIZE > 1) ? $clog2(MODEL_SIZE) : 1;
    localparam int MW    = (MAT > 1) ? $clog2(MAT) : 1;
    localparam int EW    = $clog2(NENT);

    logic signed [QW-1:0] offset_reg [MODEL_SIZE];
    logic signed [QW-1:0] matrix_reg [MAT];
    logic signed [QW-1:0] gain_reg   [NENT];
    logic signed [QW-1:0] lower_reg  [MAT];
    logic signed [QW-1:0] upper_reg  [MAT];
    logic signed [QW-1:0] meas_reg   [MODEL_SIZE];
    logic signed [QW-1:0] drive_reg  [MODEL_SIZE];
    logic signed [QW-1:0] err_reg    [MODEL_SIZE];
    logic signed [QW-1:0] newv_reg   [NENT];
    logic signed [QW-1:0] acc_reg;
    logic signed [QW-1:0] tmp_reg;
    logic signed [QW-1:0] prod_reg;
    logic                 pv_reg;
    logic [4:0]           res_index_reg;
    logic signed [QW-1:0] res_value_reg;

    logic [RW-1:0] row;
    logic [RW-1:0] col;
    logic [MW-1:0] mi;
    logic [EW-1:0] ei;
    logic signed [QW-1:0] op_a;
    logic signed [QW-1:0] op_b;
    logic signed [63:0]   full;
    logic signed [QW-1:0] qprod;
    logic signed [QW-1:0] upd;
    logic signed [QW-1:0] clamped;

    assign row = cmd.row[RW-1:0];
    assign col = cmd.col[RW-1:0];
    assign mi  = MW'(32'(row) * MODEL_SIZE + 32'(col));
    assign ei  = cmd.entry[EW-1:0];

    always_comb
    begin
        unique case (cmd.sel_a)
            SRC_GAIN:   op_a = gain_reg[ei];
            SRC_MATRIX: op_a = matrix_reg[mi];
            default:    op_a = tmp_reg;
        endcase
        unique case (cmd.sel_b)
            SRC_DRIVE: op_b = drive_reg[col];
            SRC_SQRT:  op_b = $signed({15'd0, sqrt_dt});
            default:   op_b = err_reg[row];
        endcase
    end

    // arithmetic shift floors the dropped bits
    assign full  = op_a * op_b;
    assign qprod = sat64(full >>> 16);
    assign upd   = qadd((ei < EW'(MODEL_SIZE)) ? offset_reg[row] : matrix_reg[mi], prod_reg);

    always_comb
    begin
        clamped = upd;
        if (clamped < lower_reg[mi])
            clamped = lower_reg[mi];
        if (clamped > upper_reg[mi])
            clamped = upper_reg[mi];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MODEL_SIZE; i++)
                offset_reg[i] <= '0;
            for (int i = 0; i < MAT; i++)
            begin
                matrix_reg[i] <= '0;
                lower_reg[i]  <= Q_MIN;
                upper_reg[i]  <= Q_MAX;
            end
            for (int i = 0; i < NENT; i++)
                gain_reg[i] <= '0;
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= (cmd.op == OP_MUL) || (cmd.op == OP_EACC);
            if (wr_en && (wr_index < 5'(NENT)))
            begin
                priority case (wr_cmd)
                    CMD_GAIN:
                        gain_reg[wr_index[EW-1:0]] <= wr_value;
                    CMD_LOWER:
                        if (wr_index >= 5'(MODEL_SIZE))
                            lower_reg[MW'(wr_index - 5'(MODEL_SIZE))] <= wr_value;
                    CMD_UPPER:
                        if (wr_index >= 5'(MODEL_SIZE))
                            upper_reg[MW'(wr_index - 5'(MODEL_SIZE))] <= wr_value;
                    CMD_PARAM:
                        if (wr_index < 5'(MODEL_SIZE))
                            offset_reg[wr_index[RW-1:0]] <= wr_value;
                        else
                            matrix_reg[MW'(wr_index - 5'(MODEL_SIZE))] <= wr_value;
                    default:
                        ;
                endcase
            end
            if (cmd.op == OP_FINAL)
            begin
                for (int i = 0; i < MODEL_SIZE; i++)
                    offset_reg[i] <= newv_reg[i];
                for (int i = 0; i < MAT; i++)
                    matrix_reg[i] <= newv_reg[MODEL_SIZE + i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_en)
        begin
            for (int i = 0; i < MODEL_SIZE; i++)
            begin
                meas_reg[i]  <= (i < 4) ? ld_meas[i] : '0;
                drive_reg[i] <= (i < 4) ? ld_drive[i] : '0;
            end
        end
        prod_reg <= qprod;
        unique case (cmd.op)
            OP_EINIT:
                acc_reg <= offset_reg[row];
            OP_EACC:
                acc_reg <= qadd(acc_reg, prod_reg);
            OP_EFIN:
                err_reg[row] <= qsub(meas_reg[row], acc_reg);
            default:
                ;
        endcase
        if (cmd.load)
            tmp_reg <= prod_reg;
        if (cmd.emit)
        begin
            newv_reg[ei] <= (ei < EW'(MODEL_SIZE)) ? upd : clamped;
            res_index_reg <= cmd.entry;
            res_value_reg <= (ei < EW'(MODEL_SIZE)) ? upd : clamped;
        end
    end

    assign stat.prod_valid = pv_reg;
    assign res_index = res_index_reg;
    assign res_value = res_value_reg;

endmodule

// ===== design/lmsa_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsa_control
// step sequencer: error pass, then per-entry product chains and result words
// ----------------------------------------------------------------------------
module lmsa_control #(
    parameter int MODEL_SIZE = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lmsa_pkg::lmsa_stat_t   stat,
    output lmsa_pkg::lmsa_cmd_t    cmd,
    output logic                  busy,
    output logic                  res_valid,
    output logic                  res_last,
    input  logic                  res_stall
);
    import lmsa_pkg::*;

    localparam int NENT = MODEL_SIZE + MODEL_SIZE * MODEL_SIZE;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EINIT = 4'd1;
    localparam logic [3:0] S_EMUL  = 4'd2;
    localparam logic [3:0] S_EACC  = 4'd3;
    localparam logic [3:0] S_EFIN  = 4'd4;
    localparam logic [3:0] S_M1    = 4'd5;
    localparam logic [3:0] S_M2    = 4'd6;
    localparam logic [3:0] S_M3    = 4'd7;
    localparam logic [3:0] S_M4    = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_M2B   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [3:0] row_reg, row_next;
    logic [3:0] col_reg, col_next;
    logic [4:0] ent_reg, ent_next;
    logic       is_off;

    assign is_off = ent_reg < 5'(MODEL_SIZE);

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ent_next   = ent_reg;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.entry  = ent_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = S_EINIT;
                end
            S_EINIT:
            begin
                cmd.op     = OP_EINIT;
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.op     = OP_MUL;
                cmd.sel_a  = SRC_MATRIX;
                cmd.sel_b  = SRC_DRIVE;
                state_next = S_EACC;
            end
            S_EACC:
            begin
                if (stat.prod_valid)
                begin
                    cmd.op = OP_EACC;
                    if (col_reg == 4'(MODEL_SIZE - 1))
                    begin
                        col_next   = '0;
                        state_next = S_EFIN;
                    end
                    else
                    begin
                        col_next   = col_reg + 4'd1;
                        state_next = S_EMUL;
                    end
                end
            end
            S_EFIN:
            begin
                cmd.op = OP_EFIN;
                if (row_reg == 4'(MODEL_SIZE - 1))
                begin
                    row_next   = '0;
                    col_next   = '0;
                    ent_next   = '0;
                    state_next = S_M1;
                end
                else
                begin
                    row_next   = row_reg + 4'd1;
                    state_next = S_EINIT;
                end
            end
            // offsets: g*s, *e ; matrix: g*u, *s, *e
            S_M1:
            begin
                cmd.op     = OP_MUL;
                cmd.sel_a  = SRC_GAIN;
                cmd.sel_b  = is_off ? SRC_SQRT : SRC_DRIVE;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.load   = 1'b1;
                state_next = is_off ? S_M4 : S_M3;
            end
            S_M3:
            begin
                cmd.op     = OP_MUL;
                cmd.sel_a  = SRC_TMP;
                cmd.sel_b  = SRC_SQRT;
                state_next = S_M2B;
            end
            S_M4:
            begin
                cmd.op     = OP_MUL;
                cmd.sel_a  = SRC_TMP;
                cmd.sel_b  = SRC_ERR;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.emit   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (!res_stall)
                begin
                    if (ent_reg == 5'(NENT - 1))
                        state_next = S_FIN;
                    else
                    begin
                        ent_next = ent_reg + 5'd1;
                        if (ent_reg >= 5'(MODEL_SIZE))
                        begin
                            if (col_reg == 4'(MODEL_SIZE - 1))
                            begin
                                col_next = '0;
                                row_next = row_reg + 4'd1;
                            end
                            else
                                col_next = col_reg + 4'd1;
                        end
                        else if (ent_reg == 5'(MODEL_SIZE - 1))
                        begin
                            row_next = '0;
                            col_next = '0;
                        end
                        else
                            row_next = row_reg + 4'd1;
                        state_next = S_M1;
                    end
                end
            S_M2B:
            begin
                cmd.load   = 1'b1;
                state_next = S_M4;
            end
            S_FIN:
            begin
                cmd.op     = OP_FINAL;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            ent_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            ent_reg   <= ent_next;
        end
    end

    assign busy      = state_reg != S_IDLE;
    assign res_valid = state_reg == S_OUT;
    assign res_last  = ent_reg == 5'(NENT - 1);

endmodule

// ===== design/lms_affine_param_estimator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_affine_param_estimator_unit
// online gradient estimator of an affine model y = a + B u, Q16.16
// ----------------------------------------------------------------------------
// A step word runs an error pass and then a product chain per offset entry and
// per matrix entry on the single shared 32x32 multiplier, and a closing step;
// any output stall lengthens it. Write words produce no result. Only one word
// is in work at a time; in_stall is high while a step is in progress. Each
// result word is held until taken.
module lms_affine_param_estimator_unit #(
    parameter int MODEL_SIZE = lmsa_pkg::MODEL_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [4:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] meas_0,
    input  logic signed [31:0] meas_1,
    input  logic signed [31:0] meas_2,
    input  logic signed [31:0] meas_3,
    input  logic signed [31:0] drive_0,
    input  logic signed [31:0] drive_1,
    input  logic signed [31:0] drive_2,
    input  logic signed [31:0] drive_3,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [4:0]         out_index,
    output logic signed [31:0] out_value,
    output logic               last_entry
);
    import lmsa_pkg::*;

    logic [16:0]         sqrt_dt_reg;
    logic                acc_in;
    logic                busy;
    logic                start;
    lmsa_cmd_t           cmd;
    lmsa_stat_t          stat;
    logic signed [31:0]  meas [4];
    logic signed [31:0]  drive [4];

    assign meas  = '{meas_0, meas_1, meas_2, meas_3};
    assign drive = '{drive_0, drive_1, drive_2, drive_3};

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign acc_in    = in_valid && !busy;
    assign start     = acc_in && (command == CMD_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqrt_dt_reg <= '0;
        else if (cfg_valid && cfg_ready)
            sqrt_dt_reg <= cfg_data;
    end

    lmsa_control #(.MODEL_SIZE(MODEL_SIZE)) u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .res_valid (out_valid),
        .res_last  (last_entry),
        .res_stall (out_stall)
    );

    lmsa_datapath #(.MODEL_SIZE(MODEL_SIZE)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .wr_en     (acc_in && (command != CMD_STEP)),
        .wr_cmd    (command),
        .wr_index  (entry_index),
        .wr_value  (entry_value),
        .ld_en     (start),
        .ld_meas   (meas),
        .ld_drive  (drive),
        .sqrt_dt   (sqrt_dt_reg),
        .res_index (out_index),
        .res_value (out_value)
    );

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_entry && out_valid |-> out_index == 5'(MODEL_SIZE * (MODEL_SIZE + 1) - 1))
        else $error("last word on wrong entry");

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result shown while idle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("step accepted but not started");

endmodule

// ===== tb/sv/lms_affine_param_estimator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_affine_param_estimator_unit_test
// drives step and write words with random idling on both sides, predicts the
// 20 updated entries of every step in q16.16 and checks each result word
// ----------------------------------------------------------------------------
import lmsa_pkg::*;

class lmsa_scoreboard;
    logic signed [31:0] offs[4];
    logic signed [31:0] mat[16];
    logic signed [31:0] gain[20];
    logic signed [31:0] lo[16];
    logic signed [31:0] hi[16];
    logic [16:0] sdt;
    logic [4:0] want_idx[$];
    logic signed [31:0] want_val[$];
    logic want_last[$];
    int errors;

    function new();
        for (int i = 0; i < 4; i++) offs[i] = '0;
        for (int i = 0; i < 16; i++)
        begin
            mat[i] = '0;
            lo[i] = Q_MIN;
            hi[i] = Q_MAX;
        end
        for (int i = 0; i < 20; i++) gain[i] = '0;
        sdt = '0;
        errors = 0;
    endfunction

    function logic signed [31:0] sat(logic signed [63:0] v);
        if (v > 64'sd2147483647) return Q_MAX;
        if (v < -64'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    function logic signed [31:0] mul(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat(p >>> 16);
    endfunction

    function logic signed [31:0] add(logic signed [31:0] a, logic signed [31:0] b);
        return sat(64'(a) + 64'(b));
    endfunction

    function void note_input(logic [2:0] cmd, logic [4:0] idx, logic signed [31:0] val,
                             logic signed [31:0] y[4], logic signed [31:0] u[4]);
        logic signed [31:0] e[4];
        logic signed [31:0] na[4];
        logic signed [31:0] nb[16];
        logic signed [31:0] acc;
        logic signed [31:0] t;
        logic signed [31:0] s;
        if (cmd != CMD_STEP)
        begin
            if (idx >= 20) return;
            if (cmd == CMD_GAIN) gain[idx] = val;
            else if (cmd == CMD_LOWER && idx >= 4) lo[idx-4] = val;
            else if (cmd == CMD_UPPER && idx >= 4) hi[idx-4] = val;
            else if (cmd == CMD_PARAM)
            begin
                if (idx < 4) offs[idx] = val;
                else mat[idx-4] = val;
            end
            return;
        end
        s = 32'(sdt);
        for (int i = 0; i < 4; i++)
        begin
            acc = offs[i];
            for (int j = 0; j < 4; j++) acc = add(acc, mul(mat[i*4+j], u[j]));
            e[i] = sat(64'(y[i]) - 64'(acc));
        end
        for (int i = 0; i < 4; i++) na[i] = add(offs[i], mul(mul(gain[i], s), e[i]));
        for (int k = 0; k < 16; k++)
        begin
            t = mul(gain[4+k], u[k%4]);
            t = mul(mul(t, s), e[k/4]);
            t = add(mat[k], t);
            if (t < lo[k]) t = lo[k];
            if (t > hi[k]) t = hi[k];
            nb[k] = t;
        end
        for (int k = 0; k < 20; k++)
        begin
            if (k < 4) offs[k] = na[k];
            else mat[k-4] = nb[k-4];
            want_idx.push_back(5'(k));
            want_val.push_back(k < 4 ? na[k] : nb[k-4]);
            want_last.push_back(k == 19);
        end
    endfunction

    function void check_result(logic [4:0] idx, logic signed [31:0] val, logic last);
        logic [4:0] ei;
        logic signed [31:0] ev;
        logic el;
        if (want_idx.size() == 0)
        begin
            errors++;
            if (errors <= 10) $display("unexpected word idx=%0d val=%h", idx, val);
            return;
        end
        ei = want_idx.pop_front();
        ev = want_val.pop_front();
        el = want_last.pop_front();
        if (ei !== idx || ev !== val || el !== last)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch exp idx=%0d val=%h last=%b got idx=%0d val=%h last=%b",
                         ei, ev, el, idx, val, last);
        end
    endfunction
endclass

module lms_affine_param_estimator_unit_test;
    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [16:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [2:0] command;
    logic [4:0] entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] meas_0, meas_1, meas_2, meas_3;
    logic signed [31:0] drive_0, drive_1, drive_2, drive_3;
    logic out_valid;
    logic out_stall;
    logic [4:0] out_index;
    logic signed [31:0] out_value;
    logic last_entry;

    lmsa_scoreboard sb;
    bit quiet;
    int cycles;

    lms_affine_param_estimator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .entry_index(entry_index), .entry_value(entry_value),
        .meas_0(meas_0), .meas_1(meas_1), .meas_2(meas_2), .meas_3(meas_3),
        .drive_0(drive_0), .drive_1(drive_1), .drive_2(drive_2), .drive_3(drive_3),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_index(out_index), .out_value(out_value), .last_entry(last_entry)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_index, out_value, last_entry);

    always @(negedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 6);

    function automatic logic signed [31:0] pick();
        case ($urandom_range(7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return 32'sh0001_0000;
            4: return $signed(32'($urandom));
            default: return $signed(32'($urandom_range(262143))) - 32'sd131072;
        endcase
    endfunction

    task automatic write_sqrt_dt(logic [16:0] v);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.sdt = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic send(logic [2:0] cmd, logic [4:0] idx, logic signed [31:0] val,
                        logic signed [31:0] y[4], logic signed [31:0] u[4]);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        command <= cmd;
        entry_index <= idx;
        entry_value <= val;
        meas_0 <= y[0]; meas_1 <= y[1]; meas_2 <= y[2]; meas_3 <= y[3];
        drive_0 <= u[0]; drive_1 <= u[1]; drive_2 <= u[2]; drive_3 <= u[3];
        do @(posedge clk); while (in_stall);
        sb.note_input(cmd, idx, val, y, u);
    endtask

    task automatic random_word(int step_pct);
        logic signed [31:0] y[4];
        logic signed [31:0] u[4];
        logic [2:0] cmd;
        for (int i = 0; i < 4; i++)
        begin
            y[i] = pick();
            u[i] = pick();
        end
        if ($urandom_range(99) < step_pct) cmd = CMD_STEP;
        else cmd = 3'($urandom_range(1, 7));
        send(cmd, ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(19)),
             pick(), y, u);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.want_idx.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        logic signed [31:0] y[4];
        logic signed [31:0] u[4];
        sb = new();
        cycles = 0;
        quiet = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = '0;
        in_valid = 0;
        out_stall = 0;
        command = CMD_STEP;
        entry_index = '0;
        entry_value = '0;
        {meas_0, meas_1, meas_2, meas_3} = '0;
        {drive_0, drive_1, drive_2, drive_3} = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: gains, bounds incl. crossed and offset entries, bad index
        write_sqrt_dt(17'd65536);
        for (int i = 0; i < 4; i++)
        begin
            y[i] = 32'sh0002_0000;
            u[i] = 32'sh0001_0000;
        end
        send(CMD_STEP, 5'd0, 32'sd0, y, u);
        for (int k = 0; k < 20; k++) send(CMD_GAIN, 5'(k), 32'sh0000_8000, y, u);
        send(CMD_LOWER, 5'd2, 32'sh1000_0000, y, u);
        send(CMD_UPPER, 5'd5, Q_MIN, y, u);
        send(CMD_LOWER, 5'd6, 32'sh0001_0000, y, u);
        send(CMD_UPPER, 5'd6, 32'sh0000_1000, y, u);
        send(CMD_PARAM, 5'd25, Q_MAX, y, u);
        send(3'd6, 5'd1, Q_MAX, y, u);
        send(CMD_PARAM, 5'd0, Q_MAX, y, u);
        send(CMD_PARAM, 5'd19, Q_MIN, y, u);
        send(CMD_STEP, 5'd0, 32'sd0, y, u);
        y[0] = Q_MIN; y[1] = Q_MAX; u[0] = Q_MAX; u[3] = Q_MIN;
        send(CMD_STEP, 5'd0, 32'sd0, y, u);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_sqrt_dt(17'd0);
                1: write_sqrt_dt(17'd256);
                2: write_sqrt_dt(17'($urandom_range(65536)));
                default: write_sqrt_dt(17'd65536);
            endcase
            quiet = (ph == 2);
            for (int n = 0; n < 125; n++) random_word(25);
            drain();
        end
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
